// ===== rtl/core/prht_pkg.sv =====
package prht_pkg;

  localparam int DEF_TABLE_ENTRIES = 1024;

  localparam int KIND_W  = 2;
  localparam int PORT_W  = 16;
  localparam int RULE_W  = 10;
  localparam int CODE_W  = 3;
  localparam int CHAIN_W = 11;

  localparam int HASH_SHIFT  = 8;
  localparam int RECIP_SHIFT = 28;

  localparam logic [CHAIN_W-1:0] CHAIN_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CODE_W-1:0] RC_CLEARED   = 3'd0;
  localparam logic [CODE_W-1:0] RC_INSERTED  = 3'd1;
  localparam logic [CODE_W-1:0] RC_FULL      = 3'd2;
  localparam logic [CODE_W-1:0] RC_FOUND     = 3'd3;
  localparam logic [CODE_W-1:0] RC_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [RULE_W-1:0] rule_index;
  } prht_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [RULE_W-1:0] found_rule;
  } prht_out_t;

endpackage

// ===== rtl/core/prht_mod.sv =====
module prht_mod
  import prht_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                             clk,
  input  logic [PORT_W-1:0]                x,
  output logic [$clog2(TABLE_ENTRIES)-1:0] r
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int NUM_W  = IDX_W + 1;
  localparam int PROD_W = PORT_W + RECIP_SHIFT;
  localparam int QN_W   = PORT_W + NUM_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [RECIP_SHIFT-1:0] RECIP_C = RECIP_SHIFT'(RECIP);
  localparam logic [NUM_W-1:0]       NUM_C   = NUM_W'(TABLE_ENTRIES);

  logic [PROD_W-1:0] prod;
  logic [PORT_W-1:0] q_r;
  logic [PORT_W-1:0] x_r;
  logic [QN_W-1:0]   qn;
  logic [QN_W-1:0]   diff;
  logic [IDX_W-1:0]  r_r;

  assign prod = PROD_W'(x) * PROD_W'(RECIP_C);
  assign qn   = QN_W'(q_r) * QN_W'(NUM_C);
  assign diff = QN_W'(x_r) - qn;
  assign r    = r_r;

  always_ff @(posedge clk) begin
    q_r <= prod[PROD_W-1:RECIP_SHIFT];
    x_r <= x;
    r_r <= diff[IDX_W-1:0];
  end

endmodule

// ===== rtl/core/port_rule_hash_table.sv =====
// Port-to-rule hash table with TABLE_ENTRIES slots held in two single-port synchronous
// memories (ports, and rule plus valid). One transaction is handled at a time. An insert
// or search probes the primary slot first and then further slots as needed: each probe
// is one read of the memories, and the three hash indexes come from a two-stage
// reciprocal modulo unit. A clear writes one memory row per cycle. After reset the block
// zeroes the memories, with in_stall high.
module port_rule_hash_table
  import prht_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  prht_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output prht_out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > CHAIN_W) ? CNT_W : CHAIN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [1:0] PH_PRI = 2'd0;
  localparam logic [1:0] PH_SEC = 2'd1;
  localparam logic [1:0] PH_LIN = 2'd2;

  logic [PORT_W-1:0] port_mem [TABLE_ENTRIES];
  logic [RULE_W:0]   rule_mem [TABLE_ENTRIES];

  logic [2:0]         state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [PORT_W-1:0]  port_r, port_nxt;
  logic [RULE_W-1:0]  rule_r, rule_nxt;
  logic [1:0]         hc_r, hc_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [IDX_W-1:0]   loc_r, loc_nxt;
  logic [IDX_W-1:0]   sec_r, sec_nxt;
  logic [IDX_W-1:0]   stop_r, stop_nxt;
  logic [IDX_W-1:0]   sw_r, sw_nxt;
  logic [CNT_W-1:0]   chain_r, chain_nxt;
  logic [CHAIN_W-1:0] longest_r, longest_nxt;
  logic [CODE_W-1:0]  res_code_r, res_code_nxt;
  logic [RULE_W-1:0]  res_rule_r, res_rule_nxt;
  logic               out_valid_r;
  prht_out_t          out_data_r;

  logic [PORT_W-1:0]  rd_port_r;
  logic [RULE_W:0]    rd_rule_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wp_en;
  logic               wr_en;
  logic [IDX_W-1:0]   w_addr;
  logic [PORT_W-1:0]  wp_data;
  logic [RULE_W:0]    wr_data;

  logic [PORT_W-1:0]  mod_x;
  logic [IDX_W-1:0]   mod_r;
  logic [PORT_W-1:0]  sec_x;
  logic [PORT_W-1:0]  stop_x;
  logic [IDX_W-1:0]   loc_inc;
  logic [CNT_W-1:0]   chain_inc;
  logic [CMP_W-1:0]   chain_ext;
  logic [CMP_W-1:0]   chain_inc_ext;
  logic [CMP_W-1:0]   longest_ext;
  logic [CHAIN_W-1:0] chain_sat;
  logic               in_acc;
  logic               out_load;
  logic               slot_valid;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign sec_x  = (PORT_W'(TABLE_ENTRIES) - port_r) ^ (port_r >> HASH_SHIFT);
  assign stop_x = port_r ^ (port_r >> HASH_SHIFT);
  assign mod_x  = (state_r == ST_IDLE) ? in_data.port : ((hc_r == 2'd0) ? sec_x : stop_x);

  prht_mod #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mod (
    .clk(clk),
    .x  (mod_x),
    .r  (mod_r)
  );

  assign loc_inc       = (loc_r == LAST_IDX) ? '0 : loc_r + 1'b1;
  assign chain_inc     = chain_r + 1'b1;
  assign chain_ext     = CMP_W'(chain_r);
  assign chain_inc_ext = CMP_W'(chain_inc);
  assign longest_ext   = CMP_W'(longest_r);
  assign chain_sat     = (chain_ext > CMP_W'(CHAIN_MAX)) ? CHAIN_MAX : chain_ext[CHAIN_W-1:0];
  assign slot_valid    = rd_rule_r[RULE_W];

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    port_nxt     = port_r;
    rule_nxt     = rule_r;
    hc_nxt       = hc_r;
    phase_nxt    = phase_r;
    loc_nxt      = loc_r;
    sec_nxt      = sec_r;
    stop_nxt     = stop_r;
    sw_nxt       = sw_r;
    chain_nxt    = chain_r;
    longest_nxt  = longest_r;
    res_code_nxt = res_code_r;
    res_rule_nxt = res_rule_r;
    rd_en        = 1'b0;
    rd_addr      = loc_r;
    wp_en        = 1'b0;
    wr_en        = 1'b0;
    w_addr       = loc_r;
    wp_data      = port_r;
    wr_data      = {1'b1, rule_r};

    unique case (state_r)
      ST_INIT: begin
        wp_en   = 1'b1;
        wr_en   = 1'b1;
        w_addr  = sw_r;
        wp_data = '0;
        wr_data = '0;
        sw_nxt  = sw_r + 1'b1;
        if (sw_r == LAST_IDX) begin
          sw_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_data.kind;
          port_nxt     = in_data.port;
          rule_nxt     = in_data.rule_index;
          hc_nxt       = '0;
          sw_nxt       = '0;
          res_rule_nxt = '0;
          if (in_data.kind == KIND_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_data.kind == KIND_INSERT || in_data.kind == KIND_SEARCH) begin
            state_nxt = ST_HASH;
          end else begin
            res_code_nxt = RC_NOT_FOUND;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_HASH: begin
        hc_nxt = hc_r + 1'b1;
        if (hc_r == 2'd1) begin
          rd_en   = 1'b1;
          rd_addr = mod_r;
          loc_nxt = mod_r;
        end else if (hc_r == 2'd2) begin
          sec_nxt = mod_r;
        end else if (hc_r == 2'd3) begin
          stop_nxt  = mod_r;
          phase_nxt = PH_PRI;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (kind_r == KIND_INSERT) begin
          if (!slot_valid) begin
            wp_en = 1'b1;
            wr_en = 1'b1;
            if (phase_r == PH_LIN && chain_ext > longest_ext) begin
              longest_nxt = chain_sat;
            end
            res_code_nxt = RC_INSERTED;
            state_nxt    = ST_DONE;
          end else if (phase_r == PH_PRI) begin
            rd_en     = 1'b1;
            rd_addr   = sec_r;
            loc_nxt   = sec_r;
            phase_nxt = PH_SEC;
          end else if (phase_r == PH_SEC) begin
            rd_en     = 1'b1;
            rd_addr   = loc_inc;
            loc_nxt   = loc_inc;
            chain_nxt = '0;
            phase_nxt = PH_LIN;
          end else begin
            chain_nxt = chain_inc;
            if (loc_r == stop_r) begin
              res_code_nxt = RC_FULL;
              state_nxt    = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = loc_inc;
              loc_nxt = loc_inc;
            end
          end
        end else begin
          if (rd_port_r == port_r) begin
            res_code_nxt = slot_valid ? RC_FOUND : RC_NOT_FOUND;
            res_rule_nxt = slot_valid ? rd_rule_r[RULE_W-1:0] : '0;
            state_nxt    = ST_DONE;
          end else if (phase_r == PH_PRI) begin
            rd_en     = 1'b1;
            rd_addr   = sec_r;
            loc_nxt   = sec_r;
            phase_nxt = PH_SEC;
          end else if (phase_r == PH_SEC) begin
            rd_en     = 1'b1;
            rd_addr   = loc_inc;
            loc_nxt   = loc_inc;
            chain_nxt = '0;
            phase_nxt = PH_LIN;
          end else begin
            chain_nxt = chain_inc;
            if (loc_r == stop_r || chain_inc_ext > longest_ext) begin
              res_code_nxt = RC_NOT_FOUND;
              state_nxt    = ST_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = loc_inc;
              loc_nxt = loc_inc;
            end
          end
        end
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        w_addr  = sw_r;
        wr_data = '0;
        sw_nxt  = sw_r + 1'b1;
        if (sw_r == LAST_IDX) begin
          sw_nxt       = '0;
          longest_nxt  = '0;
          res_code_nxt = RC_CLEARED;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sw_r        <= '0;
      longest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sw_r      <= sw_nxt;
      longest_r <= longest_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    port_r     <= port_nxt;
    rule_r     <= rule_nxt;
    hc_r       <= hc_nxt;
    phase_r    <= phase_nxt;
    loc_r      <= loc_nxt;
    sec_r      <= sec_nxt;
    stop_r     <= stop_nxt;
    chain_r    <= chain_nxt;
    res_code_r <= res_code_nxt;
    res_rule_r <= res_rule_nxt;
    if (out_load) begin
      out_data_r.result_code <= res_code_r;
      out_data_r.found_rule  <= res_rule_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wp_en) begin
      port_mem[w_addr] <= wp_data;
    end
    if (rd_en) begin
      rd_port_r <= port_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[w_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_rule_r <= rule_mem[rd_addr];
    end
  end

endmodule
